// ----- rtl/efp_pkg.sv -----
package efp_pkg;

   // Frame geometry
   localparam int FRAME_BYTES = 32;
   localparam int CRC_POS     = FRAME_BYTES - 2;
   localparam int POS_RPM     = 13;
   localparam int POS_SENSOR  = 19;
   localparam int NUM_SENSORS = 5;
   localparam int CNT_W       = 6;
   localparam int COUNT_MAX   = 63;

   // Arithmetic widths
   localparam int RPM_RAW_W = 16;
   localparam int RPM_X10_W = 20;
   localparam int SCALE_W   = 16;
   localparam int PROD_W    = RPM_X10_W + SCALE_W;
   localparam int RPM_W     = 28;
   localparam int Q_FRAC    = 8;

   // CRC16-MODBUS
   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;

   localparam logic [7:0]         SENSOR_KEEP = 8'hFF;
   localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd256;

   // Result status codes
   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_CRC_ERR = 2'd1;
   localparam logic [1:0] STATUS_LEN_ERR = 2'd2;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       frame_end;
   } req_item_type;

   typedef struct packed {
      logic [1:0]       frame_status;
      logic [RPM_W-1:0] rpm_value;
      logic [15:0]      voltage_tenths;
      logic [15:0]      current_tenths;
      logic [7:0]       fet_temperature;
      logic [7:0]       bec_temperature;
      logic [7:0]       motor_temperature;
      logic [7:0]       bec_voltage;
      logic [7:0]       bec_current;
   } rsp_item_type;

   // Frame summary handed from the byte tracker to the result stage
   typedef struct packed {
      logic                             len_ok;
      logic                             crc_ok;
      logic [RPM_X10_W-1:0]             rpm_x10;
      logic [15:0]                      voltage;
      logic [15:0]                      current;
      logic [NUM_SENSORS-1:0][7:0]      sensor;
   } frame_info_type;

   // One byte through the reflected CRC16 (LSB first)
   function automatic logic [15:0] crc16_update(input logic [15:0] crc,
                                                input logic [7:0]  data);
      logic [15:0] c;
      c = crc ^ {8'h00, data};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

// ----- rtl/efp_capture.sv -----
module efp_capture (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  efp_pkg::req_item_type  item,
   output efp_pkg::frame_info_type info
);
   import efp_pkg::*;

   localparam logic [CNT_W-1:0] CNT_MAX     = CNT_W'(COUNT_MAX);
   localparam logic [CNT_W-1:0] CNT_FRAME   = CNT_W'(FRAME_BYTES);
   localparam logic [CNT_W-1:0] CNT_CRC_LO  = CNT_W'(CRC_POS);
   localparam logic [CNT_W-1:0] CNT_CRC_HI  = CNT_W'(CRC_POS + 1);
   localparam logic [CNT_W-1:0] CNT_RPM_LO  = CNT_W'(POS_RPM);
   localparam logic [CNT_W-1:0] CNT_RPM_HI  = CNT_W'(POS_RPM + 1);
   localparam logic [CNT_W-1:0] CNT_VOLT_LO = CNT_W'(POS_RPM + 2);
   localparam logic [CNT_W-1:0] CNT_VOLT_HI = CNT_W'(POS_RPM + 3);
   localparam logic [CNT_W-1:0] CNT_CURR_LO = CNT_W'(POS_RPM + 4);
   localparam logic [CNT_W-1:0] CNT_CURR_HI = CNT_W'(POS_RPM + 5);

   logic [CNT_W-1:0]            byte_count_ff, byte_count_in, count_new;
   logic                        over_ff, over_in, over_new;
   logic [15:0]                 crc_ff, crc_in, crc_new;
   logic [15:0]                 rcrc_ff, rcrc_in, rcrc_new;
   logic [RPM_RAW_W-1:0]        rpm_raw_ff, rpm_raw_in;
   logic [RPM_X10_W-1:0]        rpm_x10_ff, rpm_x10_in;
   logic [15:0]                 volt_ff, volt_in;
   logic [15:0]                 curr_ff, curr_in;
   logic [NUM_SENSORS-1:0][7:0] sensor_ff, sensor_in;
   logic                        in_range;

   assign in_range = (byte_count_ff != CNT_MAX);

   // Per-byte capture at the current position
   always_comb begin
      count_new  = byte_count_ff;
      over_new   = over_ff;
      crc_new    = crc_ff;
      rcrc_new   = rcrc_ff;
      rpm_raw_in = rpm_raw_ff;
      volt_in    = volt_ff;
      curr_in    = curr_ff;
      sensor_in  = sensor_ff;
      if (in_range) begin
         count_new = byte_count_ff + 1'b1;
         if (byte_count_ff < CNT_CRC_LO) begin
            crc_new = crc16_update(crc_ff, item.rx_byte);
         end
         if (byte_count_ff == CNT_CRC_LO) begin
            rcrc_new[7:0] = item.rx_byte;
         end
         if (byte_count_ff == CNT_CRC_HI) begin
            rcrc_new[15:8] = item.rx_byte;
         end
         case (byte_count_ff)
            CNT_RPM_LO:  rpm_raw_in[7:0]  = item.rx_byte;
            CNT_RPM_HI:  rpm_raw_in[15:8] = item.rx_byte;
            CNT_VOLT_LO: volt_in[7:0]     = item.rx_byte;
            CNT_VOLT_HI: volt_in[15:8]    = item.rx_byte;
            CNT_CURR_LO: curr_in[7:0]     = item.rx_byte;
            CNT_CURR_HI: curr_in[15:8]    = item.rx_byte;
            default: ;
         endcase
         for (int i = 0; i < NUM_SENSORS; i++) begin
            if (byte_count_ff == CNT_W'(POS_SENSOR + i)) begin
               sensor_in[i] = item.rx_byte;
            end
         end
      end else begin
         over_new = 1'b1;
      end
   end

   // rpm*10 as shift-add, ready well before the frame ends
   assign rpm_x10_in = RPM_X10_W'({rpm_raw_in, 3'b000}) + RPM_X10_W'({rpm_raw_in, 1'b0});

   // Frame end returns the tracker to its start values
   always_comb begin
      if (item.frame_end) begin
         byte_count_in = '0;
         over_in       = 1'b0;
         crc_in        = CRC_INIT;
         rcrc_in       = '0;
      end else begin
         byte_count_in = count_new;
         over_in       = over_new;
         crc_in        = crc_new;
         rcrc_in       = rcrc_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff <= '0;
         over_ff       <= 1'b0;
         crc_ff        <= CRC_INIT;
         rcrc_ff       <= '0;
      end else if (step) begin
         byte_count_ff <= byte_count_in;
         over_ff       <= over_in;
         crc_ff        <= crc_in;
         rcrc_ff       <= rcrc_in;
      end
   end

   // Field captures, no reset
   always_ff @(posedge clock) begin
      if (step) begin
         rpm_raw_ff <= rpm_raw_in;
         rpm_x10_ff <= rpm_x10_in;
         volt_ff    <= volt_in;
         curr_ff    <= curr_in;
         sensor_ff  <= sensor_in;
      end
   end

   // Summary as seen after this byte
   always_comb begin
      info.len_ok  = !over_new && (count_new == CNT_FRAME);
      info.crc_ok  = (crc_new == rcrc_new);
      info.rpm_x10 = rpm_x10_ff;
      info.voltage = volt_in;
      info.current = curr_in;
      info.sensor  = sensor_in;
   end

   overflow_at_max: assert property (@(posedge clock) disable iff (reset)
      over_ff |-> (byte_count_ff == CNT_MAX))
      else $error("overflow flag set below saturated count");

   restart_after_end: assert property (@(posedge clock) disable iff (reset)
      step && item.frame_end |=> (byte_count_ff == '0) && !over_ff && (crc_ff == CRC_INIT))
      else $error("tracker not restarted after frame end");

endmodule

// ----- rtl/efp_result.sv -----
module efp_result (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_wr_en,
   input  logic [15:0]             csr_wr_data,
   input  logic                    end_step,
   input  efp_pkg::frame_info_type info,
   input  logic                    rsp_ready,
   output logic                    rsp_valid,
   output efp_pkg::rsp_item_type   rsp_item,
   output logic                    rsp_free
);
   import efp_pkg::*;

   logic [SCALE_W-1:0]          scale_ff;
   logic [1:0]                  status_ff, status_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [RPM_W-1:0]            last_rpm_ff, last_rpm_in;
   logic [15:0]                 last_volt_ff, last_volt_in;
   logic [15:0]                 last_curr_ff, last_curr_in;
   logic [NUM_SENSORS-1:0][7:0] held_ff, held_in;
   logic [PROD_W-1:0]           rpm_prod;
   logic                        frame_ok;

   // Scale register
   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= SCALE_RESET;
      end else if (csr_wr_en) begin
         scale_ff <= csr_wr_data;
      end
   end

   // Frame status
   always_comb begin
      if (!info.len_ok) begin
         status_in = STATUS_LEN_ERR;
      end else if (!info.crc_ok) begin
         status_in = STATUS_CRC_ERR;
      end else begin
         status_in = STATUS_OK;
      end
   end

   assign frame_ok = (status_in == STATUS_OK);
   assign rpm_prod = info.rpm_x10 * scale_ff;

   // Last good values update only on a clean frame
   always_comb begin
      last_rpm_in  = last_rpm_ff;
      last_volt_in = last_volt_ff;
      last_curr_in = last_curr_ff;
      held_in      = held_ff;
      if (end_step && frame_ok) begin
         last_rpm_in  = rpm_prod[Q_FRAC +: RPM_W];
         last_volt_in = info.voltage;
         last_curr_in = info.current;
         for (int i = 0; i < NUM_SENSORS; i++) begin
            if (info.sensor[i] != SENSOR_KEEP) begin
               held_in[i] = info.sensor[i];
            end
         end
      end
   end

   // Output handshake
   assign rsp_free     = !rsp_valid_ff || rsp_ready;
   assign rsp_valid_in = end_step || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         last_rpm_ff  <= '0;
         last_volt_ff <= '0;
         last_curr_ff <= '0;
         held_ff      <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         last_rpm_ff  <= last_rpm_in;
         last_volt_ff <= last_volt_in;
         last_curr_ff <= last_curr_in;
         held_ff      <= held_in;
      end
   end

   always_ff @(posedge clock) begin
      if (end_step) begin
         status_ff <= status_in;
      end
   end

   // Result item is the status plus the last good values
   assign rsp_valid = rsp_valid_ff;
   always_comb begin
      rsp_item.frame_status      = status_ff;
      rsp_item.rpm_value         = last_rpm_ff;
      rsp_item.voltage_tenths    = last_volt_ff;
      rsp_item.current_tenths    = last_curr_ff;
      rsp_item.fet_temperature   = held_ff[0];
      rsp_item.bec_temperature   = held_ff[1];
      rsp_item.motor_temperature = held_ff[2];
      rsp_item.bec_voltage       = held_ff[3];
      rsp_item.bec_current       = held_ff[4];
   end

   no_overwrite: assert property (@(posedge clock) disable iff (reset)
      end_step |-> rsp_free)
      else $error("frame result written over a pending result");

endmodule

// ----- rtl/esc_telemetry_frame_parser_core.sv -----
// ESC telemetry frame parser.
//
// req channel: one received byte per item, with frame_end marking the last
// byte before a line-idle gap. rsp channel: one result item per frame end,
// carrying a status (ok, CRC error, length error), rpm scaled by the csr
// register (unsigned 8.8), voltage and current in tenths, and five held
// sensor bytes. Error frames report the last good values.
// csr port: one write-only register, the rpm scale; write it only while idle.
//
// Throughput: one byte per cycle, except while a frame-end byte waits on a
// pending result. A byte goes into the input register, then the CRC update,
// field capture and rpm multiply feed the result register: rsp_valid rises
// once the frame-end byte has passed the input and result registers.
// Reset: scale = 1.0, byte counter cleared, CRC at 0xFFFF, held values zero, no
// result pending.
// Stall: while a result waits on rsp_ready, ordinary bytes keep flowing; a
// following frame-end byte stays in the input register and req_ready drops
// until the pending result is taken.
module esc_telemetry_frame_parser_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  efp_pkg::req_item_type req_item,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output efp_pkg::rsp_item_type rsp_item,
   input  logic                  csr_wr_en,
   input  logic [15:0]           csr_wr_data
);
   import efp_pkg::*;

   logic           in_valid_ff, in_valid_in;
   req_item_type   in_item_ff;
   logic           advance;
   logic           rsp_free;
   frame_info_type info;

   // Input register: an end byte moves on only when the result slot is free
   assign advance     = in_valid_ff && (!in_item_ff.frame_end || rsp_free);
   assign req_ready   = !in_valid_ff || advance;
   assign in_valid_in = (req_valid && req_ready) || (in_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_item_ff <= req_item;
      end
   end

   efp_capture u_capture (
      .clock (clock),
      .reset (reset),
      .step  (advance),
      .item  (in_item_ff),
      .info  (info)
   );

   efp_result u_result (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .end_step    (advance && in_item_ff.frame_end),
      .info        (info),
      .rsp_ready   (rsp_ready),
      .rsp_valid   (rsp_valid),
      .rsp_item    (rsp_item),
      .rsp_free    (rsp_free)
   );

   accept_lands: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> in_valid_ff)
      else $error("accepted byte lost from input register");

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 100ps

module tb;
   import efp_pkg::*;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   req_item_type req_item = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   rsp_item_type rsp_item;
   logic         csr_wr_en = 1'b0;
   logic [15:0]  csr_wr_data = '0;

   // no idling on either side while set
   bit steady = 1'b0;

   int mismatches = 0;
   int bytes_sent = 0;

   // results still owed by the block, oldest first
   rsp_item_type expected_results[$];

   // frame under construction
   logic [7:0] frame_buf[$];

   // parser state as the block should hold it
   logic [SCALE_W-1:0] rpm_scale = SCALE_RESET;
   int                 pk_count = 0;
   bit                 pk_over = 1'b0;
   logic [15:0]        pk_crc = CRC_INIT;
   logic [15:0]        pk_rcv_crc = '0;
   logic [15:0]        pk_rpm_raw = '0;
   logic [15:0]        pk_volt_raw = '0;
   logic [15:0]        pk_curr_raw = '0;
   logic [7:0]         pk_sens[NUM_SENSORS] = '{default: 8'h00};
   logic [7:0]         held_sens[NUM_SENSORS] = '{default: 8'h00};
   logic [RPM_W-1:0]   last_rpm = '0;
   logic [15:0]        last_volt = '0;
   logic [15:0]        last_curr = '0;

   esc_telemetry_frame_parser_core i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_item    (req_item),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_item    (rsp_item),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // hard stop
   initial begin
      #2_000_000;
      $display("FAILURE");
      $finish;
   end

   // CRC16-MODBUS, one bit at a time, LSB first
   function automatic logic [15:0] modbus_crc_byte(input logic [15:0] crc,
                                                   input logic [7:0]  b);
      logic [15:0] c;
      logic        fb;
      c = crc;
      for (int i = 0; i < 8; i++) begin
         fb = c[0] ^ b[i];
         c  = c >> 1;
         if (fb) c = c ^ CRC_POLY;
      end
      return c;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t: mismatch %s: got 0x%0h expected 0x%0h", $realtime, what, got, want);
      mismatches++;
   endtask

   // byte-level parser: capture, CRC, and the result at frame end
   task automatic parse_byte(input logic [7:0] b, input logic fe);
      rsp_item_type res;
      logic [63:0]  prod;
      if (pk_count < COUNT_MAX) begin
         if (pk_count < CRC_POS) pk_crc = modbus_crc_byte(pk_crc, b);
         else if (pk_count == CRC_POS) pk_rcv_crc[7:0] = b;
         else if (pk_count == CRC_POS + 1) pk_rcv_crc[15:8] = b;
         case (pk_count)
            POS_RPM:     pk_rpm_raw[7:0]   = b;
            POS_RPM + 1: pk_rpm_raw[15:8]  = b;
            POS_RPM + 2: pk_volt_raw[7:0]  = b;
            POS_RPM + 3: pk_volt_raw[15:8] = b;
            POS_RPM + 4: pk_curr_raw[7:0]  = b;
            POS_RPM + 5: pk_curr_raw[15:8] = b;
            default: begin
               if (pk_count >= POS_SENSOR && pk_count < POS_SENSOR + NUM_SENSORS)
                  pk_sens[pk_count - POS_SENSOR] = b;
            end
         endcase
         pk_count++;
      end else begin
         pk_over = 1'b1;
      end
      if (fe) begin
         res = '0;
         if (pk_over || pk_count != FRAME_BYTES) res.frame_status = STATUS_LEN_ERR;
         else if (pk_crc != pk_rcv_crc) res.frame_status = STATUS_CRC_ERR;
         else res.frame_status = STATUS_OK;
         // good frame: new readings, sensors keep old value on 0xFF
         if (res.frame_status == STATUS_OK) begin
            prod      = 64'(pk_rpm_raw) * 64'd10 * 64'(rpm_scale);
            last_rpm  = prod[Q_FRAC +: RPM_W];
            last_volt = pk_volt_raw;
            last_curr = pk_curr_raw;
            for (int i = 0; i < NUM_SENSORS; i++)
               if (pk_sens[i] != SENSOR_KEEP) held_sens[i] = pk_sens[i];
         end
         res.rpm_value         = last_rpm;
         res.voltage_tenths    = last_volt;
         res.current_tenths    = last_curr;
         res.fet_temperature   = held_sens[0];
         res.bec_temperature   = held_sens[1];
         res.motor_temperature = held_sens[2];
         res.bec_voltage       = held_sens[3];
         res.bec_current       = held_sens[4];
         expected_results.push_back(res);
         pk_count   = 0;
         pk_over    = 1'b0;
         pk_crc     = CRC_INIT;
         pk_rcv_crc = '0;
      end
   endtask

   // one item on the req channel, with an occasional gap before it
   task automatic send_byte(input logic [7:0] b, input logic fe);
      if (!steady && $urandom_range(99) < 7) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= '{rx_byte: b, frame_end: fe};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      parse_byte(b, fe);
      bytes_sent++;
   endtask

   task automatic send_frame();
      foreach (frame_buf[i]) send_byte(frame_buf[i], i == frame_buf.size() - 1);
   endtask

   // well-formed frame with random filler and a correct CRC
   task automatic make_frame(input logic [15:0] rpm, input logic [15:0] volt,
                             input logic [15:0] curr, input logic [39:0] sens);
      logic [15:0] crc;
      frame_buf.delete();
      for (int i = 0; i < CRC_POS; i++) frame_buf.push_back(8'($urandom));
      frame_buf[POS_RPM]     = rpm[7:0];
      frame_buf[POS_RPM + 1] = rpm[15:8];
      frame_buf[POS_RPM + 2] = volt[7:0];
      frame_buf[POS_RPM + 3] = volt[15:8];
      frame_buf[POS_RPM + 4] = curr[7:0];
      frame_buf[POS_RPM + 5] = curr[15:8];
      for (int i = 0; i < NUM_SENSORS; i++) frame_buf[POS_SENSOR + i] = sens[8*i +: 8];
      crc = CRC_INIT;
      foreach (frame_buf[i]) crc = modbus_crc_byte(crc, frame_buf[i]);
      frame_buf.push_back(crc[7:0]);
      frame_buf.push_back(crc[15:8]);
   endtask

   task automatic resize_frame(input int len);
      while (frame_buf.size() > len) void'(frame_buf.pop_back());
      while (frame_buf.size() < len) frame_buf.push_back(8'($urandom));
   endtask

   // each sensor byte is the keep code about a quarter of the time
   function automatic logic [39:0] random_sensors();
      logic [39:0] s;
      for (int i = 0; i < NUM_SENSORS; i++)
         s[8*i +: 8] = ($urandom_range(3) == 0) ? SENSOR_KEEP : 8'($urandom);
      return s;
   endfunction

   // stop sending and let every owed result come out
   task automatic finish_phase();
      req_valid <= 1'b0;
      for (int k = 0; k < 20000 && expected_results.size() > 0; k++) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic set_scale(input logic [15:0] v);
      finish_phase();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      rpm_scale = v;
   endtask

   // results before any good frame carry zeros; short frames back to back
   task automatic test_after_reset();
      send_byte(8'h5A, 1'b1);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b1);
      steady = 1'b1;
      for (int i = 0; i < 4; i++) send_byte(8'($urandom), 1'b1);
      steady = 1'b0;
   endtask

   task automatic test_good_frames();
      make_frame(16'h0000, 16'h0000, 16'h0000, 40'h00_00_00_00_00);
      send_frame();
      make_frame(16'hFFFF, 16'hFFFF, 16'hFFFF, 40'hFE_FE_FE_FE_FE);
      send_frame();
      // all keep codes: sensors hold the previous frame's bytes
      make_frame(16'($urandom), 16'($urandom), 16'($urandom), {5{SENSOR_KEEP}});
      send_frame();
      make_frame(16'h8001, 16'h1234, 16'hABCD, 40'h01_FF_80_FF_7F);
      send_frame();
      make_frame(16'($urandom), 16'($urandom), 16'($urandom), random_sensors());
      send_frame();
   endtask

   task automatic test_crc_errors();
      int pos[3] = '{CRC_POS, CRC_POS + 1, POS_RPM + 1};
      foreach (pos[i]) begin
         make_frame(16'($urandom), 16'($urandom), 16'($urandom), random_sensors());
         frame_buf[pos[i]] ^= 8'($urandom_range(1, 255));
         send_frame();
      end
   endtask

   // short, long, and past the counter's limit
   task automatic test_length_errors();
      int lens[6] = '{FRAME_BYTES - 1, FRAME_BYTES + 1, COUNT_MAX, COUNT_MAX + 1, 70, 100};
      foreach (lens[i]) begin
         make_frame(16'($urandom), 16'($urandom), 16'($urandom), random_sensors());
         resize_frame(lens[i]);
         send_frame();
      end
      // a good frame right after an overflowed one
      make_frame(16'($urandom), 16'($urandom), 16'($urandom), random_sensors());
      send_frame();
   endtask

   task automatic test_rpm_scale();
      logic [15:0] scales[6] = '{16'h0000, 16'hFFFF, 16'h0001, 16'h8000, 16'h0180, SCALE_RESET};
      foreach (scales[i]) begin
         set_scale(scales[i]);
         make_frame(16'hFFFF, 16'($urandom), 16'($urandom), random_sensors());
         send_frame();
         make_frame(16'($urandom), 16'($urandom), 16'($urandom), random_sensors());
         send_frame();
      end
   endtask

   // mostly good frames, with corrupted, mis-sized and noise bursts mixed in
   task automatic test_random();
      int          r;
      int          len;
      int          target;
      logic [15:0] rpm;
      for (int phase = 0; phase < 4; phase++) begin
         set_scale(phase == 1 ? 16'hFFFF : phase == 2 ? 16'h0000 : 16'($urandom));
         steady = (phase == 0);
         target = bytes_sent + 140;
         while (bytes_sent < target) begin
            r   = $urandom_range(99);
            rpm = ($urandom_range(9) == 0) ? 16'hFFFF : 16'($urandom);
            make_frame(rpm, 16'($urandom), 16'($urandom), random_sensors());
            if (r >= 70 && r < 80) begin
               frame_buf[$urandom_range(FRAME_BYTES - 1)] ^= 8'($urandom_range(1, 255));
            end else if (r >= 80 && r < 90) begin
               len = $urandom_range(1, 80);
               if (len == FRAME_BYTES) len++;
               resize_frame(len);
            end else if (r >= 90) begin
               frame_buf.delete();
               resize_frame($urandom_range(1, 70));
            end
            send_frame();
         end
      end
      steady = 1'b0;
   endtask

   // result side stalls
   always @(posedge clock) begin
      rsp_ready <= steady || ($urandom_range(99) >= 7);
   end

   // every accepted result against the oldest expectation
   always @(posedge clock) begin : result_check
      rsp_item_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            report_mismatch("unexpected result, status", rsp_item.frame_status, 0);
         end else begin
            want = expected_results.pop_front();
            if (rsp_item.frame_status !== want.frame_status)
               report_mismatch("frame_status", rsp_item.frame_status, want.frame_status);
            if (rsp_item.rpm_value !== want.rpm_value)
               report_mismatch("rpm_value", rsp_item.rpm_value, want.rpm_value);
            if (rsp_item.voltage_tenths !== want.voltage_tenths)
               report_mismatch("voltage_tenths", rsp_item.voltage_tenths,
                               want.voltage_tenths);
            if (rsp_item.current_tenths !== want.current_tenths)
               report_mismatch("current_tenths", rsp_item.current_tenths,
                               want.current_tenths);
            if (rsp_item.fet_temperature !== want.fet_temperature)
               report_mismatch("fet_temperature", rsp_item.fet_temperature,
                               want.fet_temperature);
            if (rsp_item.bec_temperature !== want.bec_temperature)
               report_mismatch("bec_temperature", rsp_item.bec_temperature,
                               want.bec_temperature);
            if (rsp_item.motor_temperature !== want.motor_temperature)
               report_mismatch("motor_temperature", rsp_item.motor_temperature,
                               want.motor_temperature);
            if (rsp_item.bec_voltage !== want.bec_voltage)
               report_mismatch("bec_voltage", rsp_item.bec_voltage, want.bec_voltage);
            if (rsp_item.bec_current !== want.bec_current)
               report_mismatch("bec_current", rsp_item.bec_current, want.bec_current);
         end
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_after_reset();
      test_good_frames();
      test_crc_errors();
      test_length_errors();
      test_rpm_scale();
      test_random();
      finish_phase();
      if (expected_results.size() != 0)
         report_mismatch("results never delivered", expected_results.size(), 0);
      if (mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// ----- esc_telemetry_frame_parser_core.f -----
rtl/efp_pkg.sv
rtl/efp_capture.sv
rtl/efp_result.sv
rtl/esc_telemetry_frame_parser_core.sv
dv/tb.sv
